// ===== rtl/lcgx_pkg.sv =====
package lcgx_pkg;

  // LCG step constants; the generator has full period modulo 2^32.
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_INC = 32'd1013904223;
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
  // Size of the whole address space, used by the coverage sum.
  localparam logic [32:0] FULL_SPACE = 33'h1_0000_0000;
  localparam logic [5:0] MAX_LEN = 6'd32;

  // Action codes of an input word.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_REQ = 1'b1;

  typedef struct packed {
    logic action;
    logic [5:0] entry_index;
    logic [31:0] entry_prefix;
    logic [5:0] entry_prefix_len;
  } in_word_t;

  typedef struct packed {
    logic [31:0] address;
    logic sequence_done;
  } out_word_t;

  // One exclusion entry; the length is stored already clamped to 32.
  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0] len;
  } tbl_entry_t;

  // Classified operation passed from the front end to the back end.
  typedef struct packed {
    logic is_req;
    logic [5:0] index;
    tbl_entry_t entry;
  } op_t;

  // Table write toward the match cells.
  typedef struct packed {
    logic en;
    logic [5:0] index;
    tbl_entry_t entry;
  } tbl_wr_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_COV_RD,
    B_COV_DOM,
    B_COV_ACC,
    B_MATCH,
    B_TEST,
    B_EMIT
  } back_state_t;

  // Lengths above 32 behave as 32.
  function automatic logic [5:0] eff_len(input logic [5:0] len);
    return (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

  // Mask with the top len bits set.
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'd0;
    end else if (len >= MAX_LEN) begin
      m = ALL_ONES;
    end else begin
      m = ~(ALL_ONES >> len);
    end
    return m;
  endfunction

  // One generator step, modulo 2^32.
  function automatic logic [31:0] lcg_next(input logic [31:0] x);
    return x * LCG_MUL + LCG_INC;
  endfunction

endpackage

// ===== rtl/lcgx_front.sv =====
module lcgx_front #(
  parameter int MAX_EXCLUDED = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lcgx_pkg::in_word_t   in_word,
  output logic                 push_valid,
  input  logic                 push_ready,
  output lcgx_pkg::op_t        push_op
);

  logic          valid_r, valid_nxt;
  lcgx_pkg::op_t op_r, op_nxt;
  logic          in_range;
  logic          accept;

  // The stage takes a word when empty or when its word moves on this cycle.
  assign in_ready = !valid_r || push_ready;
  assign accept = in_valid && in_ready;
  assign push_valid = valid_r;
  assign push_op = op_r;

  assign in_range = {26'd0, in_word.entry_index} < 32'(MAX_EXCLUDED);

  // Classify the word; loads to a slot beyond the table are dropped here.
  always_comb begin
    valid_nxt = valid_r;
    op_nxt = op_r;
    if (accept) begin
      valid_nxt = (in_word.action == lcgx_pkg::ACT_REQ) || in_range;
      op_nxt.is_req = (in_word.action == lcgx_pkg::ACT_REQ);
      op_nxt.index = in_word.entry_index;
      op_nxt.entry.prefix = in_word.entry_prefix;
      op_nxt.entry.len = lcgx_pkg::eff_len(in_word.entry_prefix_len);
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    op_r <= op_nxt;
  end

endmodule

// ===== rtl/lcgx_queue.sv =====
module lcgx_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  lcgx_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output lcgx_pkg::op_t pop_op
);

  lcgx_pkg::op_t ent_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_op = ent_r[rp_r];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wp_nxt = do_push ? ~wp_r : wp_r;
    rp_nxt = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_op;
    end
  end

endmodule

// ===== rtl/lcgx_cells.sv =====
module lcgx_cells #(
  parameter int MAX_EXCLUDED = 64,
  localparam int AW = (MAX_EXCLUDED > 1) ? $clog2(MAX_EXCLUDED) : 1,
  localparam int CW = $clog2(MAX_EXCLUDED + 1)
) (
  input  logic                    clk,
  input  lcgx_pkg::tbl_wr_t       tbl_wr,
  input  logic [CW-1:0]           n,
  input  logic [31:0]             cand,
  input  lcgx_pkg::tbl_entry_t    bcast,
  input  logic [AW-1:0]           bcast_idx,
  output logic [MAX_EXCLUDED-1:0] match_bits,
  output logic [MAX_EXCLUDED-1:0] dom_bits
);

  logic [31:0]         pfx_r [MAX_EXCLUDED];
  logic [5:0]          len_r [MAX_EXCLUDED];
  logic [MAX_EXCLUDED-1:0] match_r;
  logic [MAX_EXCLUDED-1:0] dom_r;
  logic [AW+5:0]       widx;
  logic [AW-1:0]       waddr;

  assign widx = {{AW{1'b0}}, tbl_wr.index};
  assign waddr = widx[AW-1:0];
  assign match_bits = match_r;
  assign dom_bits = dom_r;

  // One cell per table slot: its own entry, its own comparators.
  for (genvar g = 0; g < MAX_EXCLUDED; g++) begin : g_cell
    logic [31:0] mask;
    logic        active;
    logic        well_formed;
    logic        contains;
    logic        later_twin;
    logic        self;

    always_comb begin
      mask = lcgx_pkg::len_mask(len_r[g]);
      active = CW'(g) < n;
      // An entry with prefix bits below its length never matches anything.
      well_formed = (pfx_r[g] & ~mask) == 32'd0;
      contains = (len_r[g] <= bcast.len) && ((bcast.prefix & mask) == pfx_r[g]);
      // Of two identical entries only the lower slot is kept.
      later_twin = (len_r[g] == bcast.len) && (AW'(g) > bcast_idx);
      self = (AW'(g) == bcast_idx);
    end

    always_ff @(posedge clk) begin
      if (tbl_wr.en && (waddr == AW'(g))) begin
        pfx_r[g] <= tbl_wr.entry.prefix;
        len_r[g] <= tbl_wr.entry.len;
      end
      match_r[g] <= active && ((cand & mask) == pfx_r[g]);
      dom_r[g] <= active && well_formed && contains && !later_twin && !self;
    end
  end

endmodule

// ===== rtl/lcgx_back.sv =====
module lcgx_back #(
  parameter int MAX_EXCLUDED = 64,
  localparam int AW = (MAX_EXCLUDED > 1) ? $clog2(MAX_EXCLUDED) : 1,
  localparam int CW = $clog2(MAX_EXCLUDED + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [6:0]              cfg_wdata,
  input  logic                    op_valid,
  output logic                    op_ready,
  input  lcgx_pkg::op_t           op,
  output logic                    out_valid,
  input  logic                    out_ready,
  output lcgx_pkg::out_word_t     out_word,
  output lcgx_pkg::tbl_wr_t       tbl_wr,
  output logic [CW-1:0]           n,
  output logic [31:0]             cand,
  output lcgx_pkg::tbl_entry_t    bcast,
  output logic [AW-1:0]           bcast_idx,
  input  logic [MAX_EXCLUDED-1:0] match_bits,
  input  logic [MAX_EXCLUDED-1:0] dom_bits
);

  lcgx_pkg::back_state_t state_r, state_nxt;
  logic [6:0]            active_r, active_nxt;
  logic [31:0]           lcg_r, lcg_nxt;
  logic                  finished_r, finished_nxt;
  logic [31:0]           cand_r, cand_nxt;
  logic                  cov_ok_r, cov_ok_nxt;
  logic                  covered_r, covered_nxt;
  logic [AW-1:0]         i_r, i_nxt;
  logic [32:0]           acc_r, acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lcgx_pkg::out_word_t   out_word_r, out_word_nxt;

  // Shadow copy of the table, read one slot at a time by the coverage sweep.
  lcgx_pkg::tbl_entry_t  mem [MAX_EXCLUDED];
  lcgx_pkg::tbl_entry_t  rd_r;
  logic                  rd_en;
  logic [AW+5:0]         widx;
  logic [AW-1:0]         waddr;

  logic                  out_free;
  logic [31:0]           step_src;
  logic [31:0]           cand_step;
  logic                  last_i;
  logic                  rd_well_formed;
  logic [32:0]           rd_size;
  logic [32:0]           acc_sum;

  assign out_valid = out_valid_r;
  assign out_word = out_word_r;
  assign cand = cand_r;
  assign bcast = rd_r;
  assign bcast_idx = i_r;

  // Live entry count, saturated at the table depth.
  assign n = ({25'd0, active_r} > 32'(MAX_EXCLUDED)) ? CW'(MAX_EXCLUDED) : CW'(active_r);

  assign widx = {{AW{1'b0}}, op.index};
  assign waddr = widx[AW-1:0];

  assign out_free = !out_valid_r || out_ready;

  // One shared multiplier: the first step starts from the state, later ones
  // from the rejected candidate.
  assign step_src = (state_r == lcgx_pkg::B_TEST) ? cand_r : lcg_r;
  assign cand_step = lcgx_pkg::lcg_next(step_src);

  // Sweep arithmetic for the slot held in rd_r.
  assign last_i = (CW'(i_r) == (n - CW'(1)));
  assign rd_well_formed = (rd_r.prefix & ~lcgx_pkg::len_mask(rd_r.len)) == 32'd0;
  assign rd_size = 33'd1 << (lcgx_pkg::MAX_LEN - rd_r.len);
  assign acc_sum = (rd_well_formed && !(|dom_bits)) ? acc_r + rd_size : acc_r;

  // Sequencer: next state and outputs.
  always_comb begin
    state_nxt = state_r;
    active_nxt = cfg_we ? cfg_wdata : active_r;
    lcg_nxt = lcg_r;
    finished_nxt = finished_r;
    cand_nxt = cand_r;
    cov_ok_nxt = cfg_we ? 1'b0 : cov_ok_r;
    covered_nxt = covered_r;
    i_nxt = i_r;
    acc_nxt = acc_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    out_word_nxt = out_word_r;
    op_ready = 1'b0;
    rd_en = 1'b0;
    tbl_wr.en = 1'b0;
    tbl_wr.index = op.index;
    tbl_wr.entry = op.entry;

    unique case (state_r)
      lcgx_pkg::B_IDLE: begin
        if (op_valid) begin
          priority if (op.is_req == lcgx_pkg::ACT_LOAD) begin
            // Table write; the cached coverage answer is stale afterward.
            tbl_wr.en = 1'b1;
            op_ready = 1'b1;
            cov_ok_nxt = 1'b0;
          end else if (finished_r) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_word_nxt = '{address: 32'd0, sequence_done: 1'b1};
              op_ready = 1'b1;
            end
          end else if (!cov_ok_r) begin
            if (n == CW'(0)) begin
              cov_ok_nxt = 1'b1;
              covered_nxt = 1'b0;
            end else begin
              i_nxt = '0;
              acc_nxt = 33'd0;
              state_nxt = lcgx_pkg::B_COV_RD;
            end
          end else if (covered_r) begin
            // Nothing left to visit; the finished path then answers the request.
            finished_nxt = 1'b1;
          end else begin
            cand_nxt = cand_step;
            state_nxt = lcgx_pkg::B_MATCH;
          end
        end
      end

      lcgx_pkg::B_COV_RD: begin
        rd_en = 1'b1;
        state_nxt = lcgx_pkg::B_COV_DOM;
      end

      lcgx_pkg::B_COV_DOM: begin
        state_nxt = lcgx_pkg::B_COV_ACC;
      end

      // Add the size of each well-formed entry that no other live entry contains; the
      // survivors are disjoint, so full coverage means the sum is 2^32.
      lcgx_pkg::B_COV_ACC: begin
        acc_nxt = acc_sum;
        if (last_i) begin
          cov_ok_nxt = 1'b1;
          covered_nxt = (acc_sum == lcgx_pkg::FULL_SPACE);
          state_nxt = lcgx_pkg::B_IDLE;
        end else begin
          i_nxt = i_r + AW'(1);
          state_nxt = lcgx_pkg::B_COV_RD;
        end
      end

      lcgx_pkg::B_MATCH: begin
        state_nxt = lcgx_pkg::B_TEST;
      end

      lcgx_pkg::B_TEST: begin
        if (|match_bits) begin
          cand_nxt = cand_step;
          state_nxt = lcgx_pkg::B_MATCH;
        end else begin
          lcg_nxt = cand_r;
          if (cand_r == 32'd0) begin
            finished_nxt = 1'b1;
          end
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_word_nxt = '{address: cand_r, sequence_done: (cand_r == 32'd0)};
            op_ready = 1'b1;
            state_nxt = lcgx_pkg::B_IDLE;
          end else begin
            state_nxt = lcgx_pkg::B_EMIT;
          end
        end
      end

      lcgx_pkg::B_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt = '{address: cand_r, sequence_done: (cand_r == 32'd0)};
          op_ready = 1'b1;
          state_nxt = lcgx_pkg::B_IDLE;
        end
      end

      default: begin
        state_nxt = lcgx_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcgx_pkg::B_IDLE;
      active_r <= 7'd0;
      lcg_r <= 32'd0;
      finished_r <= 1'b0;
      cov_ok_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      active_r <= active_nxt;
      lcg_r <= lcg_nxt;
      finished_r <= finished_nxt;
      cov_ok_r <= cov_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cand_r <= cand_nxt;
    covered_r <= covered_nxt;
    i_r <= i_nxt;
    acc_r <= acc_nxt;
    out_word_r <= out_word_nxt;
  end

  // Table shadow memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (tbl_wr.en) begin
      mem[waddr] <= op.entry;
    end
    if (rd_en) begin
      rd_r <= mem[i_r];
    end
  end

`ifndef NO_ASSERTIONS
  // A final-address result is only ever shown once the generator has finished.
  a_done_implies_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.sequence_done) |-> finished_r)
    else $error("sequence_done shown while generator not finished");

  // Only address zero may carry sequence_done.
  a_nonzero_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.address != 32'd0)) |-> !out_word_r.sequence_done)
    else $error("nonzero address flagged as final");

  // The search runs only for a request still held at the queue head.
  a_search_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcgx_pkg::B_MATCH || state_r == lcgx_pkg::B_TEST)
      |-> (op_valid && (op.is_req == lcgx_pkg::ACT_REQ)))
    else $error("address search without a pending request");

  // The coverage sweep never reads beyond the live entries.
  a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcgx_pkg::B_COV_RD || state_r == lcgx_pkg::B_COV_DOM ||
     state_r == lcgx_pkg::B_COV_ACC) |-> (CW'(i_r) < n))
    else $error("coverage sweep index out of range");
`endif

endmodule

// ===== rtl/lcg_address_generator_with_exclusion.sv =====
// Load word: input stage, queue head, table write; 1 load per cycle while the back end is idle.
// Request: input stage, queue head, then the back end, serving one request at a time: it steps
// the generator and the cells register the match; an allowed candidate goes to the output register,
// an excluded one is stepped again. After finish, or once all are excluded, sequence_done is sent.
// A table or count change makes the next request sweep the table, reading each live entry in turn.
// Synchronous active-low reset clears generator, finish flag and count; table stays undefined.
module lcg_address_generator_with_exclusion #(
  parameter int MAX_EXCLUDED = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcgx_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output lcgx_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata
);

  localparam int AW = (MAX_EXCLUDED > 1) ? $clog2(MAX_EXCLUDED) : 1;
  localparam int CW = $clog2(MAX_EXCLUDED + 1);

  logic                    push_valid, push_ready;
  lcgx_pkg::op_t           push_op;
  logic                    pop_valid, pop_ready;
  lcgx_pkg::op_t           pop_op;
  lcgx_pkg::tbl_wr_t       tbl_wr;
  logic [CW-1:0]           n;
  logic [31:0]             cand;
  lcgx_pkg::tbl_entry_t    bcast;
  logic [AW-1:0]           bcast_idx;
  logic [MAX_EXCLUDED-1:0] match_bits;
  logic [MAX_EXCLUDED-1:0] dom_bits;

  // Front end: accept and classify words.
  lcgx_front #(.MAX_EXCLUDED(MAX_EXCLUDED)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  // Operation queue between the two halves.
  lcgx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  // Back end: table writes, coverage sweep, generator search.
  lcgx_back #(.MAX_EXCLUDED(MAX_EXCLUDED)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .op_valid   (pop_valid),
    .op_ready   (pop_ready),
    .op         (pop_op),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .tbl_wr     (tbl_wr),
    .n          (n),
    .cand       (cand),
    .bcast      (bcast),
    .bcast_idx  (bcast_idx),
    .match_bits (match_bits),
    .dom_bits   (dom_bits)
  );

  // Row of exclusion cells, one comparator set per slot.
  lcgx_cells #(.MAX_EXCLUDED(MAX_EXCLUDED)) u_cells (
    .clk        (clk),
    .tbl_wr     (tbl_wr),
    .n          (n),
    .cand       (cand),
    .bcast      (bcast),
    .bcast_idx  (bcast_idx),
    .match_bits (match_bits),
    .dom_bits   (dom_bits)
  );

endmodule
